FILE: sv/fps_pkg.sv
// Shared types, constants and helper functions of the flowlet path selector.
package fps_pkg;

    localparam int TABLE_INDEX_BITS = 10;
    localparam int TABLE_DEPTH      = 1 << TABLE_INDEX_BITS;

    localparam int HASH_W  = 32;
    localparam int COUNT_W = 5;
    localparam int RAND_W  = 16;
    localparam int PATH_W  = 4;
    localparam int STAT_W  = 2;

    localparam logic [COUNT_W-1:0] MAX_PATHS = COUNT_W'(16);

    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_HIT   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_STALE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_MISS  = 2'd2;

    typedef struct packed {
        logic present;
        logic valid;
        logic aged;
    } flag_t;

    typedef struct packed {
        logic [HASH_W-1:0] tag;
        logic [PATH_W-1:0] path;
    } entry_t;

    localparam flag_t FLAG_RESET = '{present: 1'b0, valid: 1'b0, aged: 1'b1};
    localparam flag_t FLAG_USED  = '{present: 1'b1, valid: 1'b1, aged: 1'b0};

    // Zero is taken as one path, and counts above the limit saturate.
    function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] count_in);
        logic [COUNT_W-1:0] result;
        result = count_in;
        if (count_in == '0)
        begin
            result = COUNT_W'(1);
        end
        else if (count_in > MAX_PATHS)
        begin
            result = MAX_PATHS;
        end
        return result;
    endfunction

    // Eight restoring remainder steps, one dividend bit each, most significant first.
    function automatic logic [COUNT_W-1:0] mod_step8(input logic [COUNT_W-1:0] rem_in,
                                                     input logic [7:0] bits_in,
                                                     input logic [COUNT_W-1:0] divisor);
        logic [COUNT_W-1:0] rem;
        logic [COUNT_W:0]   acc;
        rem = rem_in;
        acc = '0;
        for (int i = 7; i >= 0; i--)
        begin
            acc = {rem, bits_in[i]};
            if (acc >= {1'b0, divisor})
            begin
                acc = acc - {1'b0, divisor};
            end
            rem = acc[COUNT_W-1:0];
        end
        return rem;
    endfunction

endpackage

FILE: sv/fps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/flowlet_path_selector_core.sv
// Top level of the flowlet path selector: direct-mapped flow table with aging.
//
// A packet beat's result enters the output register after these steps: the
// table read is issued at acceptance, S_LOOKUP runs the upper half of the
// random-modulo-count reduction (eight remainder steps), and S_FINISH runs the
// lower half together with the write-back of the entry. The request side is
// ready again only after S_FINISH, so a new packet is not taken before the
// previous one is through; S_FINISH waits while the previous result has not
// been taken.
// A tick beat walks every table entry through the flag memory's single read
// and write ports, one entry per cycle, and holds the request side until the
// sweep ends. After reset a clearing pass initializes the flag memory, during
// which no request is accepted. Tag and path live in a second memory that is
// never cleared, since they are used only for entries marked present.
module flowlet_path_selector_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic                        req_type,
    input  logic [fps_pkg::HASH_W-1:0]  flow_hash,
    input  logic [fps_pkg::COUNT_W-1:0] path_count,
    input  logic [fps_pkg::RAND_W-1:0]  random_value,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [fps_pkg::PATH_W-1:0]  path_index,
    output logic [fps_pkg::STAT_W-1:0]  lookup_status
);

    localparam int IDX = fps_pkg::TABLE_INDEX_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_LOOKUP,
        S_FINISH
    } state_t;

    state_t                        state_reg;
    logic [IDX:0]                  cnt_reg;
    logic [fps_pkg::HASH_W-1:0]    hash_reg;
    logic [fps_pkg::COUNT_W-1:0]   count_reg;
    logic [fps_pkg::RAND_W-1:0]    rnd_reg;
    logic [fps_pkg::COUNT_W-1:0]   rem_reg;
    logic                          rsp_valid_reg;
    logic [fps_pkg::PATH_W-1:0]    path_reg;
    logic [fps_pkg::STAT_W-1:0]    status_reg;

    logic                          req_fire;
    logic                          finish_fire;
    logic [IDX:0]                  cnt_prev;
    logic [fps_pkg::COUNT_W-1:0]   rem_next;
    logic [fps_pkg::PATH_W-1:0]    fresh_path;
    logic                          hit;
    logic [fps_pkg::PATH_W-1:0]    path_next;
    logic [fps_pkg::STAT_W-1:0]    status_next;

    logic                          flag_we;
    logic [IDX-1:0]                flag_wr_addr;
    fps_pkg::flag_t                flag_wr_data;
    logic                          flag_re;
    logic [IDX-1:0]                flag_rd_addr;
    fps_pkg::flag_t                flag_rd_data;
    fps_pkg::flag_t                flag_aged;

    logic                          entry_re;
    fps_pkg::entry_t               entry_wr_data;
    fps_pkg::entry_t               entry_rd_data;

    logic                          clear_we;
    logic                          sweep_we;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;

    assign finish_fire = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);
    assign cnt_prev    = cnt_reg - 1'b1;

    // Second half of the reduction finishes the fresh path choice.
    assign rem_next   = fps_pkg::mod_step8(rem_reg, rnd_reg[7:0], count_reg);
    assign fresh_path = rem_next[fps_pkg::PATH_W-1:0];

    assign hit = flag_rd_data.present && (entry_rd_data.tag == hash_reg);

    always_comb
    begin
        if (hit && flag_rd_data.valid)
        begin
            path_next   = entry_rd_data.path;
            status_next = fps_pkg::STATUS_HIT;
        end
        else if (hit)
        begin
            path_next   = fresh_path;
            status_next = fps_pkg::STATUS_STALE;
        end
        else
        begin
            path_next   = fresh_path;
            status_next = fps_pkg::STATUS_MISS;
        end
    end

    // Aging of one swept entry.
    always_comb
    begin
        flag_aged = flag_rd_data;
        if (flag_rd_data.present)
        begin
            if (!flag_rd_data.aged)
            begin
                flag_aged.aged = 1'b1;
            end
            else
            begin
                flag_aged.valid = 1'b0;
            end
        end
    end

    assign clear_we = (state_reg == S_CLEAR);
    assign sweep_we = (state_reg == S_SWEEP) && (cnt_reg != '0);

    always_comb
    begin
        flag_we      = 1'b0;
        flag_wr_addr = hash_reg[IDX-1:0];
        flag_wr_data = fps_pkg::FLAG_USED;
        if (clear_we)
        begin
            flag_we      = 1'b1;
            flag_wr_addr = cnt_reg[IDX-1:0];
            flag_wr_data = fps_pkg::FLAG_RESET;
        end
        else if (sweep_we)
        begin
            flag_we      = 1'b1;
            flag_wr_addr = cnt_prev[IDX-1:0];
            flag_wr_data = flag_aged;
        end
        else if (finish_fire)
        begin
            flag_we = 1'b1;
        end
    end

    always_comb
    begin
        if (state_reg == S_SWEEP)
        begin
            flag_re      = !cnt_reg[IDX];
            flag_rd_addr = cnt_reg[IDX-1:0];
        end
        else
        begin
            flag_re      = req_fire && (req_type == fps_pkg::REQ_PACKET);
            flag_rd_addr = flow_hash[IDX-1:0];
        end
    end

    assign entry_re      = req_fire && (req_type == fps_pkg::REQ_PACKET);
    assign entry_wr_data = '{tag: hash_reg, path: path_next};

    fps_ram #(
        .WIDTH ($bits(fps_pkg::flag_t)),
        .DEPTH (fps_pkg::TABLE_DEPTH)
    ) u_flag_ram (
        .clk     (clk),
        .wr_en   (flag_we),
        .wr_addr (flag_wr_addr),
        .wr_data (flag_wr_data),
        .rd_en   (flag_re),
        .rd_addr (flag_rd_addr),
        .rd_data (flag_rd_data)
    );

    fps_ram #(
        .WIDTH ($bits(fps_pkg::entry_t)),
        .DEPTH (fps_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (finish_fire),
        .wr_addr (hash_reg[IDX-1:0]),
        .wr_data (entry_wr_data),
        .rd_en   (entry_re),
        .rd_addr (flow_hash[IDX-1:0]),
        .rd_data (entry_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (cnt_reg[IDX-1:0] == {IDX{1'b1}})
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        if (req_type == fps_pkg::REQ_TICK)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_SWEEP;
                        end
                        else
                        begin
                            hash_reg  <= flow_hash;
                            count_reg <= fps_pkg::sat_count(path_count);
                            rnd_reg   <= random_value;
                            state_reg <= S_LOOKUP;
                        end
                    end
                end
                S_SWEEP:
                begin
                    if (cnt_reg[IDX])
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_LOOKUP:
                begin
                    rem_reg   <= fps_pkg::mod_step8('0, rnd_reg[15:8], count_reg);
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (finish_fire)
                    begin
                        path_reg   <= path_next;
                        status_reg <= status_next;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign path_index    = path_reg;
    assign lookup_status = status_reg;

    // At most one source drives the flag memory's write port in any cycle.
    a_flag_write_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({clear_we, sweep_we, finish_fire}))
        else $error("flag memory write port driven by more than one source");

    // The sweep writes back exactly the entry it read in the cycle before.
    a_sweep_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (sweep_we && $past(state_reg == S_SWEEP)) |->
            (flag_wr_addr == $past(flag_rd_addr)))
        else $error("sweep write-back address does not follow the read address");

    // A packet passes through S_LOOKUP to the finishing step after acceptance.
    a_packet_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req_type == fps_pkg::REQ_PACKET)) |=> ##1 (state_reg == S_FINISH))
        else $error("packet did not reach the finishing step on time");

    // A new result appears only together with the write-back of its entry.
    a_result_with_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(finish_fire))
        else $error("result raised without a table write-back");

endmodule
